// ===== rtl/wfd_pkg.sv =====
// Shared types, widths and command codes for the wheel force-feedback command decoder.
`timescale 1ns / 1ps

package wfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 16;
    localparam int LEVEL_W = 11;
    localparam int TGT_W   = 2;
    localparam int SLOTS   = 4;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = SLOT_W + 1;

    localparam logic [POS_W-1:0] FULL_SCALE_RST = 16'hFFFF;

    // frame opcodes (first byte)
    localparam logic [BYTE_W-1:0] OP_CENTER     = 8'h0B;
    localparam logic [BYTE_W-1:0] OP_RESET      = 8'hFF;
    localparam logic [BYTE_W-1:0] OP_INIT       = 8'h81;
    localparam logic [BYTE_W-1:0] OP_AUTO_TURN  = 8'hFC;
    localparam logic [BYTE_W-1:0] OP_FORCE_ON   = 8'h80;
    localparam logic [BYTE_W-1:0] OP_SET_AMT_A  = 8'h84;
    localparam logic [BYTE_W-1:0] OP_SET_AMT_B  = 8'h9E;
    localparam logic [BYTE_W-1:0] OP_KEEP_A     = 8'hFA;
    localparam logic [BYTE_W-1:0] OP_KEEP_B     = 8'hFD;
    localparam logic [BYTE_W-1:0] OP_RUMBLE     = 8'hFB;

    // rumble strength selectors (third byte)
    localparam logic [BYTE_W-1:0] RMB_LOW       = 8'h00;
    localparam logic [BYTE_W-1:0] RMB_MID       = 8'h02;
    localparam logic [BYTE_W-1:0] RMB_HIGH      = 8'h10;
    localparam logic [BYTE_W-1:0] RMB_MAX_A     = 8'h0B;
    localparam logic [BYTE_W-1:0] RMB_MAX_B     = 8'h1B;

    // reply codes
    localparam logic [BYTE_W-1:0] RC_READY      = 8'h00;
    localparam logic [BYTE_W-1:0] RC_NOT_INIT   = 8'h11;
    localparam logic [BYTE_W-1:0] RC_BUSY       = 8'h44;

    // output levels
    localparam logic signed [LEVEL_W-1:0] LVL_ZERO        = 11'sd0;
    localparam logic signed [LEVEL_W-1:0] LVL_CENTER_FULL = 11'sd100;
    localparam logic signed [LEVEL_W-1:0] LVL_RUMBLE_LOW  = 11'sd10;
    localparam logic signed [LEVEL_W-1:0] LVL_RUMBLE_MID  = 11'sd20;
    localparam logic signed [LEVEL_W-1:0] LVL_RUMBLE_HIGH = 11'sd50;
    localparam logic signed [LEVEL_W-1:0] LVL_RUMBLE_MAX  = 11'sd80;
    localparam logic signed [LEVEL_W-1:0] LVL_AUTO_TURN   = 11'sd51;
    localparam logic signed [LEVEL_W-1:0] LVL_AMT_RST     = 11'sd26;
    localparam logic signed [LEVEL_W-1:0] LVL_AMT_BIAS    = 11'sd512;

    // index of the frame byte that completes a frame
    localparam logic [SLOT_W-1:0] FRAME_LAST = 2'd3;

    typedef enum logic [TGT_W-1:0] {
        TGT_FORCE  = 2'd0,
        TGT_CENTER = 2'd1,
        TGT_RUMBLE = 2'd2,
        TGT_REPLY  = 2'd3
    } wfd_target_t;

    typedef struct packed {
        wfd_target_t                 target;
        logic signed [LEVEL_W-1:0]   level;
    } wfd_result_t;

    typedef struct packed {
        wfd_result_t [SLOTS-1:0]     ent;
        logic [CNT_W-1:0]            count;
    } wfd_bundle_t;

endpackage

// ===== rtl/wfd_cmd_if.sv =====
// Command byte channel: received byte plus the wheel position sample.
`timescale 1ns / 1ps

interface wfd_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [wfd_pkg::BYTE_W-1:0]  rx_byte;
    logic [wfd_pkg::POS_W-1:0]   wheel_pos;

    modport source (output valid, rx_byte, wheel_pos, input ready);
    modport sink   (input valid, rx_byte, wheel_pos, output ready);
endinterface

// ===== rtl/wfd_res_if.sv =====
// Result channel: actuator target, level and end-of-frame mark.
`timescale 1ns / 1ps

interface wfd_res_if;
    logic                                valid;
    logic                                ready;
    logic [wfd_pkg::TGT_W-1:0]           target;
    logic signed [wfd_pkg::LEVEL_W-1:0]  level;
    logic                                last;

    modport source (output valid, target, level, last, input ready);
    modport sink   (input valid, target, level, last, output ready);
endinterface

// ===== rtl/wfd_cfg_if.sv =====
// Configuration write channel carrying the wheel full-scale value.
`timescale 1ns / 1ps

interface wfd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [wfd_pkg::POS_W-1:0]   wheel_full_scale;

    modport source (output valid, wheel_full_scale, input ready);
    modport sink   (input valid, wheel_full_scale, output ready);
endinterface

// ===== rtl/wfd_frame_decoder.sv =====
// Frame assembly, decoder state and single-pass decode of a completed frame.
`timescale 1ns / 1ps

module wfd_frame_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [wfd_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [wfd_pkg::POS_W-1:0]     wheel_pos,
    input  logic [wfd_pkg::POS_W-1:0]     full_scale,
    output logic                          complete,
    output wfd_pkg::wfd_bundle_t          bundle
);
    import wfd_pkg::*;

    localparam int LIM_W = POS_W + 4;

    logic [BYTE_W-1:0]          frame_reg [FRAME_LAST];
    logic [SLOT_W-1:0]          byte_count_reg;
    logic [BYTE_W-1:0]          reply_reg, reply_next;
    logic                       auto_reg, auto_next;
    logic signed [LEVEL_W-1:0]  force_reg, force_next;

    logic [LIM_W-1:0]           pos10, hi_lim, lo_lim;
    logic                       amt_pos, amt_neg, blocked;
    logic [BYTE_W-1:0]          b0, b1, b2;
    logic signed [LEVEL_W-1:0]  amt_step;
    logic [CNT_W-1:0]           n;
    wfd_bundle_t                bnd;

    assign complete = (byte_count_reg == FRAME_LAST);
    assign b0 = frame_reg[0];
    assign b1 = frame_reg[1];
    assign b2 = frame_reg[2];

    assign pos10  = {1'b0, wheel_pos, 3'b000} + {3'b000, wheel_pos, 1'b0};
    assign hi_lim = {1'b0, full_scale, 3'b000} + {4'b0000, full_scale};
    assign lo_lim = {4'b0000, full_scale};

    assign amt_neg = force_reg[LEVEL_W-1];
    assign amt_pos = !force_reg[LEVEL_W-1] && (force_reg != LVL_ZERO);
    assign blocked = ((pos10 >= hi_lim) && amt_pos) || ((pos10 <= lo_lim) && amt_neg);

    // four times the third byte, as a positive 11-bit quantity
    assign amt_step = $signed({1'b0, b2, 2'b00});

    always_comb
    begin
        reply_next = reply_reg;
        auto_next  = auto_reg;
        force_next = force_reg;
        n          = '0;
        bnd        = '0;

        case (b0)
            OP_CENTER:
            begin
                bnd.ent[n[SLOT_W-1:0]] = '{TGT_CENTER, LVL_CENTER_FULL};
                n = n + 1'b1;
            end
            OP_RESET:
            begin
                reply_next = RC_READY;
            end
            OP_INIT:
            begin
                reply_next = RC_NOT_INIT;
            end
            OP_AUTO_TURN:
            begin
                bnd.ent[n[SLOT_W-1:0]] = '{TGT_CENTER, LVL_ZERO};
                n = n + 1'b1;
                auto_next = 1'b1;
            end
            OP_FORCE_ON:
            begin
                if (b1 == 8'd0 && b2 == 8'd0)
                begin
                    bnd.ent[n[SLOT_W-1:0]] = '{TGT_FORCE, LVL_ZERO};
                    n = n + 1'b1;
                end
                if (b1 == 8'd1 && b2 == 8'd1 && !blocked)
                begin
                    bnd.ent[n[SLOT_W-1:0]] = '{TGT_FORCE, force_reg};
                    n = n + 1'b1;
                end
            end
            OP_SET_AMT_A, OP_SET_AMT_B:
            begin
                reply_next = RC_READY;
                if (b1 == 8'd1)
                begin
                    force_next = LVL_ZERO - amt_step;
                end
                else if (b1 == 8'd0)
                begin
                    force_next = LVL_AMT_BIAS - amt_step;
                end
                bnd.ent[n[SLOT_W-1:0]] = '{TGT_FORCE, force_next};
                n = n + 1'b1;
            end
            OP_KEEP_A, OP_KEEP_B:
            begin
                if (auto_reg)
                begin
                    reply_next = RC_BUSY;
                    bnd.ent[n[SLOT_W-1:0]] = '{TGT_FORCE, LVL_AUTO_TURN};
                    n = n + 1'b1;
                    if (pos10 > hi_lim)
                    begin
                        reply_next = RC_READY;
                        auto_next  = 1'b0;
                        bnd.ent[n[SLOT_W-1:0]] = '{TGT_FORCE, LVL_ZERO};
                        n = n + 1'b1;
                    end
                end
            end
            OP_RUMBLE:
            begin
                case (b2)
                    RMB_LOW:
                    begin
                        bnd.ent[n[SLOT_W-1:0]] = '{TGT_RUMBLE, LVL_RUMBLE_LOW};
                        n = n + 1'b1;
                    end
                    RMB_MID:
                    begin
                        bnd.ent[n[SLOT_W-1:0]] = '{TGT_RUMBLE, LVL_RUMBLE_MID};
                        n = n + 1'b1;
                    end
                    RMB_HIGH:
                    begin
                        bnd.ent[n[SLOT_W-1:0]] = '{TGT_RUMBLE, LVL_RUMBLE_HIGH};
                        n = n + 1'b1;
                    end
                    RMB_MAX_A, RMB_MAX_B:
                    begin
                        bnd.ent[n[SLOT_W-1:0]] = '{TGT_RUMBLE, LVL_RUMBLE_MAX};
                        n = n + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                bnd.ent[n[SLOT_W-1:0]] = '{TGT_CENTER, LVL_CENTER_FULL};
                n = n + 1'b1;
            end
            default:
            begin
            end
        endcase

        // keep-alive frames skip the trailing force release
        if (b0 != OP_KEEP_A && b0 != OP_KEEP_B)
        begin
            bnd.ent[n[SLOT_W-1:0]] = '{TGT_FORCE, LVL_ZERO};
            n = n + 1'b1;
        end
        bnd.ent[n[SLOT_W-1:0]] = '{TGT_REPLY, $signed({3'b000, reply_next})};
        bnd.count = n + 1'b1;
    end

    assign bundle = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            reply_reg      <= RC_READY;
            auto_reg       <= 1'b0;
            force_reg      <= LVL_AMT_RST;
        end
        else if (step)
        begin
            if (complete)
            begin
                byte_count_reg <= '0;
                reply_reg      <= reply_next;
                auto_reg       <= auto_next;
                force_reg      <= force_next;
            end
            else
            begin
                byte_count_reg <= byte_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !complete)
        begin
            frame_reg[byte_count_reg] <= rx_byte;
        end
    end

endmodule

// ===== rtl/wfd_result_buffer.sv =====
// Result buffer: holds one decoded frame's results and hands them out one per transfer.
`timescale 1ns / 1ps

module wfd_result_buffer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  wfd_pkg::wfd_bundle_t   bundle,
    output logic                   free,
    wfd_res_if.source              res
);
    import wfd_pkg::*;

    logic                  valid_reg;
    logic [SLOT_W-1:0]     idx_reg;
    wfd_bundle_t           bnd_reg;
    logic [CNT_W-1:0]      cnt_m1;
    logic                  is_last, xfer;

    assign cnt_m1  = bnd_reg.count - 1'b1;
    assign is_last = (idx_reg == cnt_m1[SLOT_W-1:0]);
    assign xfer    = valid_reg && res.ready;
    assign free    = !valid_reg || (xfer && is_last);

    assign res.valid  = valid_reg;
    assign res.target = bnd_reg.ent[idx_reg].target;
    assign res.level  = bnd_reg.ent[idx_reg].level;
    assign res.last   = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (xfer)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bnd_reg <= bundle;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result buffer loaded while still holding results");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, idx_reg} < bnd_reg.count))
        else $error("result index past frame result count");

    a_last_is_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && is_last) |-> (bnd_reg.ent[idx_reg].target == TGT_REPLY))
        else $error("frame run does not end with reply byte");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && is_last && !load) |=> !valid_reg)
        else $error("result buffer still valid after final transfer");
`endif

endmodule

// ===== rtl/wheel_ffb_command_decoder.sv =====
// Top level of the wheel force-feedback command decoder.
//
//  channel  role   payload                          transfer when
//  cmd      sink   rx_byte[7:0], wheel_pos[15:0]    cmd.valid && cmd.ready
//  res      src    target[1:0], level[10:0], last   res.valid && res.ready
//  cfg      sink   wheel_full_scale[15:0]           cfg.valid && cfg.ready
//
// One byte per cycle is taken unless a frame-ending byte is held; the decode of a completed
// 4-byte frame runs in one pass from the input register into the result buffer, which then
// gives 1 to 4 results at one per cycle while res.ready is high. The frame-ending byte waits
// in the input register until the result buffer has handed out its final result.
// rst_n resets the frame count, reply code, auto-turn flag, force amount (26/256) and
// full scale (65535). cfg.ready is always high.
`timescale 1ns / 1ps

module wheel_ffb_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    wfd_cmd_if.sink     cmd,
    wfd_res_if.source   res,
    wfd_cfg_if.sink     cfg
);
    import wfd_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    full_scale_reg;

    logic                complete, free, advance, load;
    wfd_bundle_t         bundle;

    // a frame-ending byte moves on only when the buffer can take its results
    assign advance   = in_valid_reg && (!complete || free);
    assign load      = advance && complete;
    assign cmd.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            full_scale_reg <= FULL_SCALE_RST;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                full_scale_reg <= cfg.wheel_full_scale;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            byte_reg <= cmd.rx_byte;
            pos_reg  <= cmd.wheel_pos;
        end
    end

    wfd_frame_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (byte_reg),
        .wheel_pos  (pos_reg),
        .full_scale (full_scale_reg),
        .complete   (complete),
        .bundle     (bundle)
    );

    wfd_result_buffer u_results (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (bundle),
        .free   (free),
        .res    (res)
    );

endmodule
